// ===== hw/rtl/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants for the checked base64 decoder.
// Holds the word types of both channels, the result codes, the queue entry
// passed from the front end to the back end, and the alphabet lookup.
// ----------------------------------------------------------------------------
package b64d_pkg;

   // Result codes carried in the kind field.
   typedef enum logic [2:0] {
      KIND_DATA     = 3'd0,
      KIND_END_OK   = 3'd1,
      KIND_BAD_CHAR = 3'd2,
      KIND_LENGTH   = 3'd3,
      KIND_BAD_PAD  = 3'd4
   } kind_type;

   // Input word: one character or an end-of-message marker.
   typedef struct packed {
      logic [7:0] symbol;
      logic       end_marker;
   } req_type;

   // Output word: one decoded byte or one status code.
   typedef struct packed {
      logic [7:0] data_byte;
      kind_type   kind;
      logic       last;
   } rsp_type;

   // One group of results caused by a single input word.
   // The count holds 1 to 3; unused bytes are zero.
   typedef struct packed {
      logic [7:0] data0;
      logic [7:0] data1;
      logic [7:0] data2;
      logic [1:0] count;
      kind_type   kind;
   } entry_type;

   // Character codes with special meaning.
   localparam logic [7:0] PAD_CHAR     = 8'h3D;
   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

   // Default depth of the queue between front end and back end.
   localparam int QUEUE_DEPTH = 4;

   // Alphabet lookup result.
   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } sextet_type;

   // Maps a character to its 6-bit value; ok is low outside the alphabet.
   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type r;
      r.ok    = 1'b1;
      r.value = 6'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r.value = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r.value = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r.value = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         r.value = 6'd62;
      end else if (c == 8'h2F) begin
         r.value = 6'd63;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/base64_decoder_checked.sv =====
// ----------------------------------------------------------------------------
// base64_decoder_checked: base64 decoder with status results.
// Takes one input word per cycle while the result queue has room.
// Results leave one word per cycle unless stalled, so a three-byte group
// leaves as three words; the result queue absorbs the difference.
// Synchronous reset clears decode state and the queue; no clearing pass.
// ----------------------------------------------------------------------------
module base64_decoder_checked #(
   parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  b64d_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output b64d_pkg::rsp_type  rsp_data
);
   import b64d_pkg::*;

   logic      push;
   entry_type push_entry;
   logic      queue_full;
   logic      pop;
   logic      not_empty;
   entry_type head;

   // Front end: classification and decode state.
   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   // Queue of result groups.
   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (not_empty),
      .head       (head)
   );

   // Back end: one result word per cycle while the output is not stalled.
   b64d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/b64d_front.sv =====
// ----------------------------------------------------------------------------
// b64d_front: input classification and decode state.
// Accepts one word per cycle unless the queue is full, tracks the pending
// symbols of the current quantum and queues a result group when one is due.
// ----------------------------------------------------------------------------
module b64d_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  b64d_pkg::req_type    req_data,
   output logic                 push,
   output b64d_pkg::entry_type  push_entry,
   input  logic                 queue_full
);
   import b64d_pkg::*;

   logic [5:0] sextet_ff [3];
   logic [5:0] sextet_in [3];
   logic [1:0] index_ff, index_in;
   logic       stopped_ff, stopped_in;
   logic       error_ff, error_in;

   logic       accept;
   sextet_type look;
   logic [7:0] b0, b1, b2;

   // Stall only when the queue has no room left.
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   assign look = sextet_of(req_data.symbol);

   // Bytes assembled from the pending symbols and the new one.
   assign b0 = {sextet_ff[0], sextet_ff[1][5:4]};
   assign b1 = {sextet_ff[1][3:0], sextet_ff[2][5:2]};
   assign b2 = {sextet_ff[2][1:0], look.value};

   // Next state and queue push for the accepted word.
   always_comb begin
      sextet_in  = sextet_ff;
      index_in   = index_ff;
      stopped_in = stopped_ff;
      error_in   = error_ff;
      push       = 1'b0;
      push_entry = '{data0: 8'd0, data1: 8'd0, data2: 8'd0, count: 2'd1,
                     kind: KIND_DATA};
      if (accept) begin
         if (req_data.end_marker) begin
            // End of message: report once unless an error already closed it.
            if (!error_ff) begin
               push = 1'b1;
               push_entry.kind = (!stopped_ff && index_ff != 2'd0) ?
                                 KIND_LENGTH : KIND_END_OK;
            end
            index_in   = 2'd0;
            stopped_in = 1'b0;
            error_in   = 1'b0;
         end else if (stopped_ff || req_data.symbol == NEWLINE_CHAR) begin
            // Ignored character.
         end else if (req_data.symbol == PAD_CHAR) begin
            stopped_in = 1'b1;
            push       = 1'b1;
            if (index_ff == 2'd2) begin
               push_entry.data0 = b0;
            end else if (index_ff == 2'd3) begin
               push_entry.data0 = b0;
               push_entry.data1 = b1;
               push_entry.count = 2'd2;
            end else begin
               error_in        = 1'b1;
               push_entry.kind = KIND_BAD_PAD;
            end
         end else if (!look.ok) begin
            stopped_in      = 1'b1;
            error_in        = 1'b1;
            push            = 1'b1;
            push_entry.kind = KIND_BAD_CHAR;
         end else if (index_ff == 2'd3) begin
            // Fourth symbol completes a quantum of three bytes.
            push             = 1'b1;
            push_entry.data0 = b0;
            push_entry.data1 = b1;
            push_entry.data2 = b2;
            push_entry.count = 2'd3;
            index_in         = 2'd0;
         end else begin
            for (int i = 0; i < 3; i++) begin
               if (index_ff == 2'(i)) begin
                  sextet_in[i] = look.value;
               end
            end
            index_in = index_ff + 2'd1;
         end
      end
   end

   // Symbol store holds payload only and needs no reset.
   always_ff @(posedge clock) begin
      sextet_ff <= sextet_in;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff   <= 2'd0;
         stopped_ff <= 1'b0;
         error_ff   <= 1'b0;
      end else begin
         index_ff   <= index_in;
         stopped_ff <= stopped_in;
         error_ff   <= error_in;
      end
   end

endmodule

// ===== hw/rtl/b64d_queue.sv =====
// ----------------------------------------------------------------------------
// b64d_queue: result group queue.
// A small first-in first-out buffer between front end and back end, so the
// input keeps moving while the output works through multi-byte groups.
// ----------------------------------------------------------------------------
module b64d_queue #(
   parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  b64d_pkg::entry_type  push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output b64d_pkg::entry_type  head
);
   import b64d_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Storage is written at the write pointer.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hw/rtl/b64d_back.sv =====
// ----------------------------------------------------------------------------
// b64d_back: result serializer.
// Walks the head group of the queue one word per cycle unless stalled and
// releases the group once its last word has been taken.
// ----------------------------------------------------------------------------
module b64d_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 not_empty,
   input  b64d_pkg::entry_type  head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output b64d_pkg::rsp_type    rsp_data
);
   import b64d_pkg::*;

   logic [1:0] pos_ff, pos_in;
   logic       is_last;

   assign rsp_valid = not_empty;
   assign is_last   = (pos_ff == head.count - 2'd1);
   assign pop       = rsp_valid && !rsp_stall && is_last;

   // Select the byte for the current position within the group.
   always_comb begin
      case (pos_ff)
         2'd0:    rsp_data.data_byte = head.data0;
         2'd1:    rsp_data.data_byte = head.data1;
         default: rsp_data.data_byte = head.data2;
      endcase
      rsp_data.kind = head.kind;
      rsp_data.last = is_last;
   end

   // Position advances on each taken word and wraps at the group's end.
   always_comb begin
      pos_in = pos_ff;
      if (rsp_valid && !rsp_stall) begin
         pos_in = is_last ? 2'd0 : pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 2'd0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

// ===== tb/base64_decoder_checked_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_decoder_checked_tb: self-checking bench for the base64 decoder.
// A fixed table of corner cases runs first, followed by random messages.
// Most random messages are well formed; the others carry bad padding, stray
// characters, a wrong length or no end marker. A model of the decoder runs
// alongside the design and builds the expected result words. Both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module base64_decoder_checked_tb;
   import b64d_pkg::*;

   localparam int RANDOM_ITEMS = 300;
   localparam int IDLE_LIMIT   = 1000;
   localparam int DRAIN_CYCLES = 16;

   // One stimulus step. Where typed is set, the row gives the result: one
   // status word of kind exp_kind, last high, if exp_n is nonzero, else none.
   typedef struct packed {
      req_type    word;
      logic       typed;
      logic [1:0] exp_n;
      kind_type   exp_kind;
   } step_row_type;

   // Corner cases, run in order right after reset.
   localparam step_row_type DIRECTED [26] = '{
      '{'{8'h00, 1'b1},         1'b1, 2'd1, KIND_END_OK},   // end on an empty message
      '{'{"A", 1'b0},           1'b0, 2'd0, KIND_DATA},
      '{'{NEWLINE_CHAR, 1'b0},  1'b1, 2'd0, KIND_DATA},     // newline is skipped
      '{'{PAD_CHAR, 1'b0},      1'b1, 2'd1, KIND_BAD_PAD},  // pad after one symbol
      '{'{"B", 1'b0},           1'b1, 2'd0, KIND_DATA},     // ignored once stopped
      '{'{8'h00, 1'b1},         1'b1, 2'd0, KIND_DATA},     // end after an error
      '{'{PAD_CHAR, 1'b0},      1'b1, 2'd1, KIND_BAD_PAD},  // pad with nothing pending
      '{'{8'hFF, 1'b1},         1'b1, 2'd0, KIND_DATA},
      '{'{"/", 1'b0},           1'b0, 2'd0, KIND_DATA},     // all-ones group
      '{'{"/", 1'b0},           1'b0, 2'd0, KIND_DATA},
      '{'{"/", 1'b0},           1'b0, 2'd0, KIND_DATA},
      '{'{"/", 1'b0},           1'b0, 2'd0, KIND_DATA},
      '{'{"A", 1'b0},           1'b0, 2'd0, KIND_DATA},
      '{'{8'h00, 1'b1},         1'b1, 2'd1, KIND_LENGTH},   // one symbol left over
      '{'{8'h00, 1'b0},         1'b1, 2'd1, KIND_BAD_CHAR},
      '{'{8'hFF, 1'b0},         1'b1, 2'd0, KIND_DATA},     // ignored once stopped
      '{'{8'h00, 1'b1},         1'b1, 2'd0, KIND_DATA},
      '{'{"Q", 1'b0},           1'b0, 2'd0, KIND_DATA},
      '{'{"w", 1'b0},           1'b0, 2'd0, KIND_DATA},
      '{'{PAD_CHAR, 1'b0},      1'b0, 2'd0, KIND_DATA},     // pad after two symbols
      '{'{8'h00, 1'b1},         1'b1, 2'd1, KIND_END_OK},
      '{'{"Z", 1'b0},           1'b0, 2'd0, KIND_DATA},
      '{'{"a", 1'b0},           1'b0, 2'd0, KIND_DATA},
      '{'{"0", 1'b0},           1'b0, 2'd0, KIND_DATA},
      '{'{PAD_CHAR, 1'b0},      1'b0, 2'd0, KIND_DATA},     // pad after three symbols
      '{'{8'h5A, 1'b1},         1'b1, 2'd1, KIND_END_OK}
   };

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   base64_decoder_checked DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Decoder model state.
   logic [5:0] held_sextet [3];
   logic [1:0] held_count;
   logic       msg_halted;
   logic       msg_failed;
   rsp_type    step_out [3];

   step_row_type stim_q [$];
   rsp_type      due_results [$];

   int      feed_idx   = 0;
   int      req_gap    = 0;
   bit      req_burst  = 1'b0;
   int      rsp_hold   = 0;
   bit      rsp_burst  = 1'b0;
   int      idle_count = 0;
   int      mismatches = 0;
   int      words_out  = 0;
   int      messages   = 0;
   int      kind_tally [8];
   rsp_type head_exp;

   function automatic rsp_type make_rsp(logic [7:0] b, kind_type k, logic l);
      rsp_type r;
      r.data_byte = b;
      r.kind      = k;
      r.last      = l;
      return r;
   endfunction

   // Returns {in_alphabet, sextet} for one character code.
   function automatic logic [6:0] alphabet_value(logic [7:0] c);
      if (c >= "A" && c <= "Z") return {1'b1, 6'(c - "A")};
      if (c >= "a" && c <= "z") return {1'b1, 6'(c - "a" + 8'd26)};
      if (c >= "0" && c <= "9") return {1'b1, 6'(c - "0" + 8'd52)};
      if (c == "+") return {1'b1, 6'd62};
      if (c == "/") return {1'b1, 6'd63};
      return 7'd0;
   endfunction

   function automatic logic [7:0] sextet_char(logic [5:0] v);
      if (v < 6'd26) return 8'("A") + 8'(v);
      if (v < 6'd52) return 8'("a") + 8'(v) - 8'd26;
      if (v < 6'd62) return 8'("0") + 8'(v) - 8'd52;
      if (v == 6'd62) return "+";
      return "/";
   endfunction

   function automatic void clear_decoder();
      held_sextet[0] = '0;
      held_sextet[1] = '0;
      held_sextet[2] = '0;
      held_count     = '0;
      msg_halted     = 1'b0;
      msg_failed     = 1'b0;
   endfunction

   // Advances the model by one input word; fills step_out, returns the count.
   function automatic int decode_word(req_type w);
      logic [6:0] lk;
      logic [5:0] s0, s1, s2;
      s0 = held_sextet[0];
      s1 = held_sextet[1];
      s2 = held_sextet[2];
      if (w.end_marker) begin
         int n;
         n = 0;
         if (!msg_failed) begin
            step_out[0] = make_rsp(8'h00, (!msg_halted && held_count != 2'd0) ?
                                   KIND_LENGTH : KIND_END_OK, 1'b1);
            n = 1;
         end
         clear_decoder();
         return n;
      end
      if (msg_halted || w.symbol == NEWLINE_CHAR) return 0;

      // Padding closes the message; it needs two or three pending symbols.
      if (w.symbol == PAD_CHAR) begin
         msg_halted = 1'b1;
         if (held_count == 2'd2) begin
            step_out[0] = make_rsp({s0, s1[5:4]}, KIND_DATA, 1'b1);
            return 1;
         end
         if (held_count == 2'd3) begin
            step_out[0] = make_rsp({s0, s1[5:4]}, KIND_DATA, 1'b0);
            step_out[1] = make_rsp({s1[3:0], s2[5:2]}, KIND_DATA, 1'b1);
            return 2;
         end
         msg_failed  = 1'b1;
         step_out[0] = make_rsp(8'h00, KIND_BAD_PAD, 1'b1);
         return 1;
      end

      lk = alphabet_value(w.symbol);
      if (!lk[6]) begin
         msg_halted  = 1'b1;
         msg_failed  = 1'b1;
         step_out[0] = make_rsp(8'h00, KIND_BAD_CHAR, 1'b1);
         return 1;
      end

      // The fourth symbol completes a group of three bytes.
      if (held_count == 2'd3) begin
         step_out[0] = make_rsp({s0, s1[5:4]}, KIND_DATA, 1'b0);
         step_out[1] = make_rsp({s1[3:0], s2[5:2]}, KIND_DATA, 1'b0);
         step_out[2] = make_rsp({s2[1:0], lk[5:0]}, KIND_DATA, 1'b1);
         held_count  = 2'd0;
         return 3;
      end
      held_sextet[held_count] = lk[5:0];
      held_count = held_count + 2'd1;
      return 0;
   endfunction

   // Books one accepted input word: runs the model and queues the results.
   function automatic void book_word(step_row_type row);
      int n;
      n = decode_word(row.word);
      if (row.word.end_marker) messages++;
      if (row.typed) begin
         if (row.exp_n != 2'd0) due_results.push_back(make_rsp(8'h00, row.exp_kind, 1'b1));
      end else begin
         for (int i = 0; i < n; i++) due_results.push_back(step_out[i]);
      end
   endfunction

   // Idle length: mostly short, now and then long, none during a burst.
   function automatic int draw_gap(bit burst);
      int r;
      if (burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(25, 60);
   endfunction

   function automatic void add_item(logic [7:0] sym, logic mark);
      step_row_type row;
      row = '0;
      row.word.symbol     = sym;
      row.word.end_marker = mark;
      stim_q.push_back(row);
   endfunction

   // Valid symbols with random content, with a newline here and there.
   function automatic void add_symbols(int count);
      for (int i = 0; i < count; i++) begin
         add_item(sextet_char(6'($urandom_range(0, 63))), 1'b0);
         if ($urandom_range(0, 9) == 0) add_item(NEWLINE_CHAR, 1'b0);
      end
   endfunction

   function automatic void add_end();
      add_item(8'($urandom_range(0, 255)), 1'b1);
   endfunction

   function automatic void build_random();
      int stop_at;
      int pick;
      int groups;
      int tail;
      stop_at = stim_q.size() + RANDOM_ITEMS;
      while (stim_q.size() < stop_at) begin
         pick   = $urandom_range(0, 99);
         groups = $urandom_range(0, 3);
         if (pick < 70) begin
            // Mostly well formed: whole groups, optionally a padded tail of two or three.
            tail = $urandom_range(0, 2);
            if (tail != 0) tail = tail + 1;
            add_symbols(4 * groups + tail);
            if (tail != 0) begin
               add_item(PAD_CHAR, 1'b0);
               if (tail == 2 && $urandom_range(0, 1) == 1) add_item(PAD_CHAR, 1'b0);
            end
            if ($urandom_range(0, 4) == 0) add_item(8'($urandom_range(0, 255)), 1'b0);
            add_end();
         end else if (pick < 78) begin
            // Symbols left over at the end.
            add_symbols(4 * groups + $urandom_range(1, 3));
            add_end();
         end else if (pick < 86) begin
            // Padding with zero or one pending symbol.
            add_symbols(4 * groups + $urandom_range(0, 1));
            add_item(PAD_CHAR, 1'b0);
            add_symbols($urandom_range(0, 2));
            add_end();
         end else if (pick < 94) begin
            // Arbitrary byte codes.
            tail = $urandom_range(1, 6);
            for (int i = 0; i < tail; i++) add_item(8'($urandom_range(0, 255)), 1'b0);
            add_end();
         end else begin
            // No end marker: runs on into the next message.
            add_symbols($urandom_range(1, 6));
         end
      end
      add_end();
   endfunction

   // Request side: book each accepted word, then present the next one
   // after a random gap. A stalled word is held unchanged.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if ($urandom_range(0, 99) == 0) req_burst = !req_burst;
         if (req_valid && !req_stall) begin
            book_word(stim_q[feed_idx]);
            feed_idx = feed_idx + 1;
            req_gap  = draw_gap(req_burst);
         end
         if (!(req_valid && req_stall)) begin
            if (req_gap > 0) begin
               req_gap = req_gap - 1;
               req_valid <= 1'b0;
            end else if (feed_idx < stim_q.size()) begin
               req_valid <= 1'b1;
               req_data  <= stim_q[feed_idx].word;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result side stall pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if ($urandom_range(0, 99) == 0) rsp_burst = !rsp_burst;
         if (rsp_hold == 0 && $urandom_range(0, 3) == 0) rsp_hold = draw_gap(rsp_burst);
         if (rsp_hold > 0) begin
            rsp_hold = rsp_hold - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Result check against the oldest expected word, plus the watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_count = 0;
         end else begin
            idle_count = idle_count + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            words_out++;
            kind_tally[int'(rsp_data.kind)]++;
            if (due_results.size() == 0) begin
               $display("%0t: unexpected result word, actual %h", $time, rsp_data);
               mismatches++;
            end else begin
               head_exp = due_results.pop_front();
               if (rsp_data.data_byte !== head_exp.data_byte) begin
                  $display("%0t: data_byte mismatch, expected %02h, actual %02h",
                           $time, head_exp.data_byte, rsp_data.data_byte);
                  mismatches++;
               end
               if (rsp_data.kind !== head_exp.kind) begin
                  $display("%0t: kind mismatch, expected %0d, actual %0d",
                           $time, head_exp.kind, rsp_data.kind);
                  mismatches++;
               end
               if (rsp_data.last !== head_exp.last) begin
                  $display("%0t: last mismatch, expected %0b, actual %0b",
                           $time, head_exp.last, rsp_data.last);
                  mismatches++;
               end
            end
         end
         if (idle_count >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, due_results.size());
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < 8; i++) kind_tally[i] = 0;
      clear_decoder();
      foreach (DIRECTED[i]) stim_q.push_back(DIRECTED[i]);
      build_random();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (feed_idx < stim_q.size() || due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d input words over %0d end markers, %0d result words checked.",
               stim_q.size(), messages, words_out);
      $display("Result kinds: data %0d, end ok %0d, bad char %0d, length %0d, bad pad %0d.",
               kind_tally[KIND_DATA], kind_tally[KIND_END_OK], kind_tally[KIND_BAD_CHAR],
               kind_tally[KIND_LENGTH], kind_tally[KIND_BAD_PAD]);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_front.sv
hw/rtl/b64d_queue.sv
hw/rtl/b64d_back.sv
hw/rtl/base64_decoder_checked.sv
tb/base64_decoder_checked_tb.sv
